[hdl/cdr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cdr_pkg;

    // largest chunk payload counted into the byte total
    localparam logic [7:0] CHUNK_BYTES_MAX = 8'd32;

    // frame function codes seen while waiting for a start
    localparam logic [3:0] KIND_COMMAND    = 4'd7;
    localparam logic [3:0] KIND_DATA_START = 4'd9;

    // low sequence bits used by the loss window
    localparam logic [7:0] SEQ_WINDOW_MASK = 8'h0F;

    // register indexes on the configuration port
    localparam logic [1:0] REG_OWN_ADDRESS   = 2'd0;
    localparam logic [1:0] REG_START_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_DATA_TIMEOUT  = 2'd2;

    // register reset values
    localparam logic [31:0] OWN_ADDRESS_RESET   = 32'd0;
    localparam logic [15:0] START_TIMEOUT_RESET = 16'd50;
    localparam logic [15:0] DATA_TIMEOUT_RESET  = 16'd1000;

    localparam logic [15:0] SLOT_COUNT_MAX = 16'hFFFF;
    localparam logic [7:0]  CRC_COUNT_MAX  = 8'hFF;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_RECV = 2'd1
    } phase_t;

    typedef enum logic [2:0] {
        ST_WAITING       = 3'd0,
        ST_STARTED       = 3'd1,
        ST_TAKEN         = 3'd2,
        ST_IDLE          = 3'd3,
        ST_DONE          = 3'd4,
        ST_START_TIMEOUT = 3'd5,
        ST_LOST          = 3'd6,
        ST_DATA_TIMEOUT  = 3'd7
    } status_t;

    typedef struct packed {
        logic [31:0] own_address;
        logic [15:0] start_timeout_slots;
        logic [15:0] data_timeout_slots;
    } cfg_t;

    typedef struct packed {
        logic        slot_end;
        logic        frame_present;
        logic        crc_good;
        logic [3:0]  frame_kind;
        logic [31:0] frame_address;
        logic [31:0] frame_mask;
        logic [7:0]  chunk_seq;
        logic [5:0]  chunk_size;
    } slot_item_t;

    typedef struct packed {
        status_t     status;
        logic        write_chunk;
        logic [31:0] total_bytes;
        logic [7:0]  next_seq;
        logic [7:0]  crc_errors;
    } result_t;

endpackage

`default_nettype wire

[hdl/cdr_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module cdr_regs
    import cdr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output cfg_t             cfg
);

    logic [31:0] own_address_reg;
    logic [15:0] start_timeout_reg;
    logic [15:0] data_timeout_reg;
    logic        wr_en;
    logic [1:0]  reg_index;

    assign reg_index = paddr[3:2];
    assign wr_en     = psel & penable & pwrite;

    // register writes in the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg   <= OWN_ADDRESS_RESET;
            start_timeout_reg <= START_TIMEOUT_RESET;
            data_timeout_reg  <= DATA_TIMEOUT_RESET;
        end else if (wr_en) begin
            unique case (reg_index)
                REG_OWN_ADDRESS:   own_address_reg   <= pwdata;
                REG_START_TIMEOUT: start_timeout_reg <= pwdata[15:0];
                REG_DATA_TIMEOUT:  data_timeout_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_index)
            REG_OWN_ADDRESS:   prdata = own_address_reg;
            REG_START_TIMEOUT: prdata = {16'd0, start_timeout_reg};
            REG_DATA_TIMEOUT:  prdata = {16'd0, data_timeout_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.own_address         = own_address_reg;
    assign cfg.start_timeout_slots = start_timeout_reg;
    assign cfg.data_timeout_slots  = data_timeout_reg;

endmodule

`default_nettype wire

[hdl/cdr_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

module cdr_engine
    import cdr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic step_en,
    input  slot_item_t item,
    input  cfg_t      cfg,
    output result_t   result
);

    phase_t      phase_reg, phase_next;
    logic [15:0] slots_reg, slots_next;
    logic [7:0]  seq_reg, seq_next;
    logic [31:0] total_reg, total_next;
    logic [7:0]  crc_reg, crc_next;
    status_t     status;
    logic        write_chunk;

    logic        good_frame;
    logic        addr_match;
    logic [15:0] wait_base;
    logic [15:0] wait_inc;
    logic [15:0] recv_inc;
    logic [7:0]  size_ext;
    logic [7:0]  size_clamped;
    logic [8:0]  seq_window;
    logic [8:0]  seq_limit;

    assign good_frame = item.frame_present & item.crc_good;
    assign addr_match = ((item.frame_address ^ cfg.own_address) & item.frame_mask) == 32'd0;

    // start wait: a good command restarts the slot count
    assign wait_base = (good_frame && item.frame_kind == KIND_COMMAND) ? 16'd0 : slots_reg;
    assign wait_inc  = (wait_base == SLOT_COUNT_MAX) ? wait_base : wait_base + 16'd1;
    assign recv_inc  = (slots_reg == SLOT_COUNT_MAX) ? slots_reg : slots_reg + 16'd1;

    // oversize chunks count as the largest chunk
    assign size_ext     = {2'b00, item.chunk_size};
    assign size_clamped = (size_ext > CHUNK_BYTES_MAX) ? CHUNK_BYTES_MAX : size_ext;

    // lost when the windowed expected sequence is more than one ahead
    assign seq_window = {1'b0, seq_reg & SEQ_WINDOW_MASK};
    assign seq_limit  = {1'b0, item.chunk_seq} + 9'd2;

    // one slot of the transfer protocol
    always_comb begin
        phase_next  = phase_reg;
        slots_next  = slots_reg;
        seq_next    = seq_reg;
        total_next  = total_reg;
        crc_next    = crc_reg;
        status      = ST_WAITING;
        write_chunk = 1'b0;
        if (phase_reg == PH_RECV) begin
            slots_next = recv_inc;
            status     = ST_IDLE;
            if (item.frame_present && !item.crc_good) begin
                crc_next = (crc_reg == CRC_COUNT_MAX) ? crc_reg : crc_reg + 8'd1;
            end
            priority if (good_frame && item.chunk_size == 6'd0) begin
                phase_next = PH_WAIT;
                slots_next = 16'd0;
                status     = ST_DONE;
            end else if (good_frame && item.chunk_seq == seq_reg) begin
                seq_next    = seq_reg + 8'd1;
                total_next  = total_reg + {24'd0, size_clamped};
                slots_next  = 16'd0;
                status      = ST_TAKEN;
                write_chunk = 1'b1;
            end else if (good_frame && seq_window >= seq_limit) begin
                phase_next = PH_WAIT;
                slots_next = 16'd0;
                status     = ST_LOST;
            end else if (recv_inc >= cfg.data_timeout_slots) begin
                phase_next = PH_WAIT;
                slots_next = 16'd0;
                status     = ST_DATA_TIMEOUT;
            end else begin
                status = ST_IDLE;
            end
        end else begin
            priority if (good_frame && item.frame_kind == KIND_DATA_START && addr_match) begin
                phase_next = PH_RECV;
                slots_next = 16'd0;
                seq_next   = 8'd0;
                total_next = 32'd0;
                crc_next   = 8'd0;
                status     = ST_STARTED;
            end else if (wait_inc >= cfg.start_timeout_slots) begin
                phase_next = PH_WAIT;
                slots_next = 16'd0;
                status     = ST_START_TIMEOUT;
            end else begin
                phase_next = PH_WAIT;
                slots_next = wait_inc;
                status     = ST_WAITING;
            end
        end
    end

    // transfer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT;
            slots_reg <= 16'd0;
            seq_reg   <= 8'd0;
            total_reg <= 32'd0;
            crc_reg   <= 8'd0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            slots_reg <= slots_next;
            seq_reg   <= seq_next;
            total_reg <= total_next;
            crc_reg   <= crc_next;
        end
    end

    assign result.status      = status;
    assign result.write_chunk = write_chunk;
    assign result.total_bytes = total_next;
    assign result.next_seq    = seq_next;
    assign result.crc_errors  = crc_next;

endmodule

`default_nettype wire

[hdl/chunked_data_receiver_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Receive side of a chunked bulk transfer, one item per listening slot.
// s_ channel: one slot event per item; tuser carries the slot flags and the
// frame kind, tdata the frame address, mask, chunk sequence and chunk size.
// Items with slot_end low are consumed and give no result.
// m_ channel: one result item per counted slot; tuser carries status and
// write_chunk, tdata the byte total, next sequence and check error count.
// APB port: own address, start timeout and data timeout at 0x0, 0x4, 0x8;
// write only while no item is in flight.
// An accepted item passes through the input register feeding the slot
// logic and then through the result register.
// Throughput: one item per cycle while results are taken; the transfer
// state updates in one pass so each slot sees the prior slot's state.
// Reset (aresetn low, synchronous) empties both registers, returns to the
// start wait with all counters at zero and restores register defaults.
// When m_tready is low the result holds; the input register takes items
// up to a slot_end item; s_tready then drops until the result is taken.
module chunked_data_receiver_top
    import cdr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // slot event
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] frame_address, [63:32] frame_mask, [71:64] chunk_seq,
    // [77:72] chunk_size, [79:78] zero
    input  wire logic [79:0] s_tdata,
    // [0] slot_end, [1] frame_present, [2] crc_good, [6:3] frame_kind
    input  wire logic [6:0]  s_tuser,
    // slot result
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] total_bytes, [39:32] next_seq, [47:40] crc_errors
    output logic [47:0]      m_tdata,
    // [2:0] status, [3] write_chunk
    output logic [3:0]       m_tuser,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic        in_valid_reg;
    logic [79:0] in_tdata_reg;
    logic [6:0]  in_tuser_reg;
    logic        out_valid_reg;
    logic [47:0] out_tdata_reg;
    logic [3:0]  out_tuser_reg;

    logic        out_free;
    logic        advance;
    logic        step_en;
    slot_item_t  item;
    cfg_t        cfg;
    result_t     result;

    assign pready = 1'b1;

    cdr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // unpack the registered item
    assign item.slot_end      = in_tuser_reg[0];
    assign item.frame_present = in_tuser_reg[1];
    assign item.crc_good      = in_tuser_reg[2];
    assign item.frame_kind    = in_tuser_reg[6:3];
    assign item.frame_address = in_tdata_reg[31:0];
    assign item.frame_mask    = in_tdata_reg[63:32];
    assign item.chunk_seq     = in_tdata_reg[71:64];
    assign item.chunk_size    = in_tdata_reg[77:72];

    // ignored items drain without needing the result register
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!item.slot_end || out_free);
    assign step_en  = advance && item.slot_end;
    assign s_tready = !in_valid_reg || advance;

    cdr_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_tdata_reg <= s_tdata;
            in_tuser_reg <= s_tuser;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_tdata_reg <= {result.crc_errors, result.next_seq, result.total_bytes};
            out_tuser_reg <= {result.write_chunk, result.status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_tuser_reg;

endmodule

`default_nettype wire

[hdl/cdr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module cdr_checker
    import cdr_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [3:0]  m_tuser
);

    // no result survives reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a chunk write comes only with a taken chunk
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> m_tuser[2:0] == ST_TAKEN)
        else $error("write_chunk without taken status");

    // a new transfer starts with cleared totals
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] == ST_STARTED |-> m_tdata == 48'd0 && !m_tuser[3])
        else $error("start result with stale totals");

    // the input side never blocks while nothing is buffered
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && $past(aresetn) && !$past(s_tvalid && s_tready) |-> s_tready)
        else $error("input stalled with empty pipeline");

endmodule

bind chunked_data_receiver_top cdr_checker u_cdr_checker (.*);

`default_nettype wire
